>>> rtl/core/aspc_pkg.sv
`default_nettype none
package aspc_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_MIN_GREEN = 2'd0;
    localparam logic [1:0] CFG_MAX_GREEN = 2'd1;
    localparam logic [1:0] CFG_SAT_FLOW  = 2'd2;

    localparam logic [7:0]  MIN_GREEN_RST = 8'd10;
    localparam logic [7:0]  MAX_GREEN_RST = 8'd45;
    localparam logic [12:0] SAT_FLOW_RST  = 13'd1800;

    // flow carry is kept in 1/3600 of a vehicle
    localparam logic [13:0] FLOW_UNIT  = 14'd3600;
    localparam logic [13:0] FLOW_UNIT2 = 14'd7200;
    localparam logic [13:0] FLOW_UNIT3 = 14'd10800;

    // score = queue * (SCORE_BASE + 2 * waited)
    localparam logic [17:0] SCORE_BASE = 18'd25;

    localparam logic [2:0] DIV_MSB = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ARRIVE,
        S_SCAN_MUL,
        S_SCAN_CMP,
        S_GRANT,
        S_DIV_CHECK,
        S_DIV,
        S_CLAMP,
        S_SERVE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic decode;
        logic arrive;
        logic scan_mul;
        logic scan_cmp;
        logic grant;
        logic div_check;
        logic div_step;
        logic clamp;
        logic serve;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic remaining_zero;
        logic scan_last;
        logic div_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/core/aspc_ctrl.sv
`default_nettype none
module aspc_ctrl
    import aspc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.is_tick) begin
                    n_state = S_ARRIVE;
                end else if (i_status.remaining_zero) begin
                    n_state = S_SCAN_MUL;
                end else begin
                    n_state = S_SERVE;
                end
            end
            S_ARRIVE:    n_state = S_FINISH;
            S_SCAN_MUL:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                n_state = i_status.scan_last ? S_GRANT : S_SCAN_MUL;
            end
            S_GRANT:     n_state = S_DIV_CHECK;
            S_DIV_CHECK: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP:     n_state = S_SERVE;
            S_SERVE:     n_state = S_FINISH;
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE:    o_cmd.decode    = 1'b1;
            S_ARRIVE:    o_cmd.arrive    = 1'b1;
            S_SCAN_MUL:  o_cmd.scan_mul  = 1'b1;
            S_SCAN_CMP:  o_cmd.scan_cmp  = 1'b1;
            S_GRANT:     o_cmd.grant     = 1'b1;
            S_DIV_CHECK: o_cmd.div_check = 1'b1;
            S_DIV:       o_cmd.div_step  = 1'b1;
            S_CLAMP:     o_cmd.clamp     = 1'b1;
            S_SERVE:     o_cmd.serve     = 1'b1;
            S_FINISH:    o_cmd.emit      = i_status.out_free;
            default:     o_cmd           = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/aspc_dp.sv
`default_nettype none
module aspc_dp
    import aspc_pkg::*;
#(
    parameter int NUM_LANES = 4,
    parameter int QUEUE_MAX = 1023
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic        i_req_type,
    input  wire logic [1:0]  i_lane_sel,
    input  wire logic        i_cfg_write,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_green_lane,
    output logic             o_new_cycle,
    output logic [7:0]       o_granted_sec,
    output logic [7:0]       o_seconds_left,
    output logic [1:0]       o_vehicles_cleared,
    output logic [9:0]       o_green_queue,
    output logic             o_arrival_dropped
);

    localparam int LW = $clog2(NUM_LANES);
    localparam int QW = $clog2(QUEUE_MAX + 1);
    localparam int PW = QW + 18;
    localparam int RW = QW + 21;

    // configuration
    logic [7:0]  r_min_green;
    logic [7:0]  r_max_green;
    logic [12:0] r_sat_flow;

    // architectural state
    logic [QW-1:0] r_queue [NUM_LANES];
    logic [15:0]   r_last  [NUM_LANES];
    logic [15:0]   r_cycle;
    logic [LW-1:0] r_active;
    logic [7:0]    r_remaining;
    logic [7:0]    r_granted;
    logic [12:0]   r_carry;

    // per item working registers
    logic          r_req;
    logic          r_sel_bad;
    logic [LW-1:0] r_addr;
    logic          r_opened;
    logic [1:0]    r_cleared;
    logic          r_dropped;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_best;
    logic [LW-1:0] r_best_lane;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_div;
    logic [7:0]    r_quo;
    logic [2:0]    r_bit;
    logic          r_sat;
    logic          r_out_valid;

    logic [QW-1:0] q_rd;
    logic [15:0]   waited;
    logic [17:0]   factor;
    logic [12:0]   flow1;
    logic          queue_full;
    logic          better;
    logic [8:0]    q9;
    logic [7:0]    clamped;
    logic [13:0]   carry_sum;
    logic [1:0]    whole;
    logic [13:0]   carry_sub;
    logic [1:0]    cleared;
    logic          serving;

    assign q_rd       = r_queue[r_addr];
    assign waited     = r_cycle - r_last[r_addr];
    assign factor     = SCORE_BASE + {1'b0, waited, 1'b0};
    assign flow1      = (r_sat_flow == '0) ? 13'd1 : r_sat_flow;
    assign queue_full = (q_rd >= QW'(QUEUE_MAX));
    assign better     = (r_prod > r_best);
    assign serving    = i_cmd.serve && (r_remaining != '0);
    assign o_out_valid = r_out_valid;

    always_comb begin
        q9 = r_sat ? 9'd256 : {1'b0, r_quo};
        if (q9 < {1'b0, r_min_green}) begin
            clamped = r_min_green;
        end else if (q9 > {1'b0, r_max_green}) begin
            clamped = r_max_green;
        end else begin
            clamped = q9[7:0];
        end
    end

    // whole vehicles in the carry after one green second
    always_comb begin
        carry_sum = {1'b0, r_carry} + {1'b0, r_sat_flow};
        if (carry_sum >= FLOW_UNIT3) begin
            whole     = 2'd3;
            carry_sub = FLOW_UNIT3;
        end else if (carry_sum >= FLOW_UNIT2) begin
            whole     = 2'd2;
            carry_sub = FLOW_UNIT2;
        end else if (carry_sum >= FLOW_UNIT) begin
            whole     = 2'd1;
            carry_sub = FLOW_UNIT;
        end else begin
            whole     = 2'd0;
            carry_sub = '0;
        end
        cleared = (QW'(whole) < q_rd) ? whole : 2'(q_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_green <= MIN_GREEN_RST;
            r_max_green <= MAX_GREEN_RST;
            r_sat_flow  <= SAT_FLOW_RST;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_MIN_GREEN: r_min_green <= i_cfg_data[7:0];
                CFG_MAX_GREEN: r_max_green <= i_cfg_data[7:0];
                CFG_SAT_FLOW:  r_sat_flow  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_queue[i] <= '0;
                r_last[i]  <= '0;
            end
        end else begin
            if (i_cmd.arrive && !r_sel_bad && !queue_full) begin
                r_queue[r_addr] <= q_rd + QW'(1);
            end else if (serving) begin
                r_queue[r_addr] <= q_rd - QW'(cleared);
            end
            if (i_cmd.grant) begin
                r_last[r_addr] <= r_cycle + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle     <= '0;
            r_active    <= '0;
            r_remaining <= '0;
            r_granted   <= '0;
            r_carry     <= '0;
            r_addr      <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_addr <= (i_lane_sel >= NUM_LANES) ? '0 : LW'(i_lane_sel);
            end
            // arrivals keep the lane address until the queue is updated
            if (i_cmd.decode && r_req) begin
                r_addr <= (r_remaining == '0) ? '0 : r_active;
            end
            if (i_cmd.arrive) begin
                r_addr <= r_active;
            end
            if (i_cmd.scan_cmp) begin
                if (r_addr == LW'(NUM_LANES - 1)) begin
                    r_addr <= better ? r_addr : r_best_lane;
                end else begin
                    r_addr <= r_addr + LW'(1);
                end
            end
            if (i_cmd.grant) begin
                r_active <= r_addr;
                r_cycle  <= r_cycle + 16'd1;
                r_carry  <= '0;
                r_bit    <= DIV_MSB;
            end
            if (i_cmd.div_step) begin
                r_bit <= r_bit - 3'd1;
            end
            if (i_cmd.clamp) begin
                r_granted   <= clamped;
                r_remaining <= clamped;
            end
            if (serving) begin
                r_carry     <= 13'(carry_sum - carry_sub);
                r_remaining <= r_remaining - 8'd1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item working registers and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_sel_bad <= (i_lane_sel >= NUM_LANES);
            r_opened  <= 1'b0;
            r_cleared <= '0;
            r_dropped <= 1'b0;
        end
        if (i_cmd.decode) begin
            r_best      <= '0;
            r_best_lane <= '0;
        end
        if (i_cmd.arrive) begin
            r_dropped <= r_sel_bad || queue_full;
        end
        if (i_cmd.scan_mul) begin
            r_prod <= PW'(q_rd) * PW'(factor);
        end
        if (i_cmd.scan_cmp && better) begin
            r_best      <= r_prod;
            r_best_lane <= r_addr;
        end
        if (i_cmd.grant) begin
            r_opened <= 1'b1;
            r_rem    <= RW'(q_rd) * RW'(FLOW_UNIT);
            r_div    <= RW'(flow1) << DIV_MSB;
            r_quo    <= '0;
        end
        if (i_cmd.div_check) begin
            r_sat <= (r_rem >= (RW'(flow1) << 8));
        end
        if (i_cmd.div_step) begin
            if (r_rem >= r_div) begin
                r_rem        <= r_rem - r_div;
                r_quo[r_bit] <= 1'b1;
            end
            r_div <= r_div >> 1;
        end
        if (serving) begin
            r_cleared <= cleared;
        end
        if (i_cmd.emit) begin
            o_green_lane       <= 2'(r_active);
            o_new_cycle        <= r_opened;
            o_granted_sec      <= r_granted;
            o_seconds_left     <= r_remaining;
            o_vehicles_cleared <= r_cleared;
            o_green_queue      <= 10'(q_rd);
            o_arrival_dropped  <= r_dropped;
        end
    end

    always_comb begin
        o_status.is_tick        = r_req;
        o_status.remaining_zero = (r_remaining == '0);
        o_status.scan_last      = (r_addr == LW'(NUM_LANES - 1));
        o_status.div_last       = (r_bit == '0);
        o_status.out_free       = !r_out_valid || i_out_ready;
    end

endmodule
`default_nettype wire

>>> rtl/core/adaptive_signal_phase_controller.sv
`default_nettype none
// Adaptive signal phase controller. Each input word is either a vehicle arrival for
// one lane or a one-second tick; each gives exactly one result word. Arrivals and
// ticks inside a running green phase go through decode and then the arrive or serve
// state. A tick that opens a new phase first scans the lanes, multiplying and then
// comparing each lane's score in turn, and gets its green time from an 8-step
// restoring divider. One word is in work at a time; the input is taken again as
// soon as the result sits in the output register, even if that result has not yet
// been taken downstream. Configuration writes are always ready.
module adaptive_signal_phase_controller
    import aspc_pkg::*;
#(
    parameter int NUM_LANES = 4,
    parameter int QUEUE_MAX = 1023
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [1:0]  i_lane_sel,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_green_lane,
    output logic             o_new_cycle,
    output logic [7:0]       o_granted_sec,
    output logic [7:0]       o_seconds_left,
    output logic [1:0]       o_vehicles_cleared,
    output logic [9:0]       o_green_queue,
    output logic             o_arrival_dropped,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    aspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    aspc_dp #(
        .NUM_LANES (NUM_LANES),
        .QUEUE_MAX (QUEUE_MAX)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_req_type         (i_req_type),
        .i_lane_sel         (i_lane_sel),
        .i_cfg_write        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_green_lane       (o_green_lane),
        .o_new_cycle        (o_new_cycle),
        .o_granted_sec      (o_granted_sec),
        .o_seconds_left     (o_seconds_left),
        .o_vehicles_cleared (o_vehicles_cleared),
        .o_green_queue      (o_green_queue),
        .o_arrival_dropped  (o_arrival_dropped)
    );

endmodule
`default_nettype wire
